// ----- src/map_slot_cache_fifo_stamp_core_assert.svh -----
// Assertion helpers for the map slot cache core.
// The clock, reset and label come from the using module.
`ifndef MAP_SLOT_CACHE_FIFO_STAMP_CORE_ASSERT_SVH
`define MAP_SLOT_CACHE_FIFO_STAMP_CORE_ASSERT_SVH

// Same-cycle implication.
`define MSFS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define MSFS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/msfs_pkg.sv -----
package msfs_pkg;

  localparam int DEF_ENTRIES    = 8;
  localparam int DEF_STAMP_BITS = 32;
  localparam int KEY_W          = 32;
  localparam int SLOT_W         = 3;

  // operation codes
  localparam logic OP_ACTIVATE = 1'b0;
  localparam logic OP_CLOSE    = 1'b1;

  // status codes
  localparam logic ST_OK     = 1'b0;
  localparam logic ST_NO_MAP = 1'b1;

  typedef struct packed {
    logic               operation;
    logic signed [31:0] map_key;
    logic               map_found;
  } req_t;

  typedef struct packed {
    logic               status;
    logic               hit;
    logic [2:0]         slot;
    logic               evicted_valid;
    logic signed [31:0] evicted_key;
    logic signed [31:0] active_key;
  } rsp_t;

endpackage

// ----- src/msfs_ram.sv -----
module msfs_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- src/map_slot_cache_fifo_stamp_core.sv -----
// Map slot cache: a fully associative cache of ENTRIES slots, each holding a
// map key and the load stamp it got when it was filled. An activate request
// returns ok for the active key, returns a cached key as a hit (its stamp is
// not refreshed, so replacement follows load order), answers a zero key with
// no-map status, and otherwise evicts the slot with the smallest stamp (slot 0
// wins ties that include it, else the highest tied index) and loads the key
// there if map_found is set. A close request empties every slot holding the
// key. When the stamp counter wraps, all slots and the active key are dropped
// before any new key is loaded. Each request gives exactly one response. After
// a request is accepted, the scan state reads the slots one by one from the
// key/stamp RAM, from the highest index down, the drain state takes in the
// last read, and the decide state decides and writes back before the core
// returns to idle to take the next request. The response sits in its own
// register, so a new request is accepted while the previous response waits;
// the decide state stalls only while an older response has not been taken yet.
// No clearing pass is needed after reset: per-slot valid flops mark empty slots.
`include "map_slot_cache_fifo_stamp_core_assert.svh"

module map_slot_cache_fifo_stamp_core #(
  parameter int ENTRIES    = msfs_pkg::DEF_ENTRIES,
  parameter int STAMP_BITS = msfs_pkg::DEF_STAMP_BITS
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_ready,
  input  msfs_pkg::req_t  req_data,
  output logic            rsp_valid,
  input  logic            rsp_ready,
  output msfs_pkg::rsp_t  rsp_data
);

  localparam int KEY_W  = msfs_pkg::KEY_W;
  localparam int SLOT_W = msfs_pkg::SLOT_W;
  localparam int IDX_W  = $clog2(ENTRIES);
  localparam int RAM_W  = KEY_W + STAMP_BITS;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DRAIN, S_DECIDE} state_t;

  state_t                 state;
  msfs_pkg::req_t         req_q;
  logic [IDX_W-1:0]       scan_idx;
  logic [IDX_W-1:0]       data_idx;
  logic                   data_pend;
  logic [ENTRIES-1:0]     valid;
  logic [ENTRIES-1:0]     valid_next;
  logic                   found_any;
  logic [IDX_W-1:0]       match_idx;
  logic [IDX_W-1:0]       best_idx;
  logic [STAMP_BITS-1:0]  best_stamp;
  logic [KEY_W-1:0]       best_key;
  logic [KEY_W-1:0]       active;
  logic [KEY_W-1:0]       active_next;
  logic [STAMP_BITS-1:0]  stamp_counter;
  logic [STAMP_BITS-1:0]  stamp_counter_next;
  msfs_pkg::rsp_t         rsp_q;
  msfs_pkg::rsp_t         rsp_next;

  // RAM side
  logic                   ram_we;
  logic [RAM_W-1:0]       ram_wdata;
  logic [RAM_W-1:0]       ram_rdata;
  logic [KEY_W-1:0]       e_key;
  logic [STAMP_BITS-1:0]  e_stamp;
  logic                   e_match;
  logic                   e_better;

  // decision terms
  logic                   is_close;
  logic                   key_nz;
  logic                   is_active;
  logic                   miss;
  logic                   victim_occ;
  logic [STAMP_BITS-1:0]  stamp_inc;
  logic                   wrap;
  logic [STAMP_BITS-1:0]  new_stamp;
  logic                   rsp_load;

  msfs_ram #(
    .WIDTH (RAM_W),
    .DEPTH (ENTRIES)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (best_idx),
    .wdata (ram_wdata),
    .re    (state == S_SCAN),
    .raddr (scan_idx),
    .rdata (ram_rdata)
  );

  // Empty slots read as key 0, stamp 0 regardless of stale RAM contents.
  assign e_key   = valid[data_idx] ? ram_rdata[RAM_W-1 -: KEY_W] : '0;
  assign e_stamp = valid[data_idx] ? ram_rdata[STAMP_BITS-1:0]  : '0;
  assign e_match = (e_key == KEY_W'(req_q.map_key));
  // Scan runs high to low: strict less keeps the highest tied index,
  // but slot 0 takes any tie.
  assign e_better = (data_idx == '0) ? (e_stamp <= best_stamp)
                                     : (e_stamp <  best_stamp);

  assign is_close   = (req_q.operation == msfs_pkg::OP_CLOSE);
  assign key_nz     = |req_q.map_key;
  assign is_active  = (KEY_W'(req_q.map_key) == active);
  assign miss       = !is_close && !is_active && key_nz && !found_any;
  assign victim_occ = |best_key;
  assign stamp_inc  = stamp_counter + STAMP_BITS'(1);
  assign wrap       = (stamp_inc == '0);
  assign new_stamp  = wrap ? STAMP_BITS'(1) : stamp_inc;

  assign req_ready = (state == S_IDLE);
  assign rsp_load  = (state == S_DECIDE) && (!rsp_valid || rsp_ready);
  assign ram_we    = rsp_load && miss && req_q.map_found;
  assign ram_wdata = {KEY_W'(req_q.map_key), new_stamp};
  assign rsp_data  = rsp_q;

  always_comb begin
    rsp_next           = '0;
    active_next        = active;
    stamp_counter_next = stamp_counter;
    priority if (is_close) begin
      if (key_nz && found_any) begin
        rsp_next.hit           = 1'b1;
        rsp_next.slot          = SLOT_W'(match_idx);
        rsp_next.evicted_valid = 1'b1;
        rsp_next.evicted_key   = req_q.map_key;
      end
    end else if (is_active) begin
      rsp_next.hit  = 1'b1;
      rsp_next.slot = found_any ? SLOT_W'(match_idx) : '0;
    end else if (!key_nz) begin
      rsp_next.status = msfs_pkg::ST_NO_MAP;
    end else if (found_any) begin
      rsp_next.hit  = 1'b1;
      rsp_next.slot = SLOT_W'(match_idx);
      active_next   = KEY_W'(req_q.map_key);
    end else begin
      rsp_next.slot = SLOT_W'(best_idx);
      if (victim_occ) begin
        rsp_next.evicted_valid = 1'b1;
        rsp_next.evicted_key   = best_key;
        if (best_key == active) begin
          active_next = '0;
        end
      end
      if (wrap) begin
        active_next = '0;
      end
      stamp_counter_next = new_stamp;
      if (req_q.map_found) begin
        active_next = KEY_W'(req_q.map_key);
      end else begin
        rsp_next.status = msfs_pkg::ST_NO_MAP;
      end
    end
    rsp_next.active_key = active_next;
  end

  always_comb begin
    valid_next = valid;
    // close empties each matching slot as it streams past
    if (data_pend && is_close && key_nz && e_match) begin
      valid_next[data_idx] = 1'b0;
    end
    if (rsp_load && miss) begin
      if (wrap) begin
        valid_next = '0;
      end else if (victim_occ) begin
        valid_next[best_idx] = 1'b0;
      end
      if (req_q.map_found) begin
        valid_next[best_idx] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      data_pend     <= 1'b0;
      valid         <= '0;
      active        <= '0;
      stamp_counter <= '0;
      rsp_valid     <= 1'b0;
      found_any     <= 1'b0;
    end else begin
      data_pend <= (state == S_SCAN);
      data_idx  <= scan_idx;
      valid     <= valid_next;

      if (data_pend) begin
        if (e_match && !found_any) begin
          found_any <= 1'b1;
          match_idx <= data_idx;
        end
        if (data_idx == LAST_IDX || e_better) begin
          best_idx   <= data_idx;
          best_stamp <= e_stamp;
          best_key   <= e_key;
        end
      end

      if (rsp_load) begin
        rsp_valid <= 1'b1;
        rsp_q     <= rsp_next;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            req_q     <= req_data;
            scan_idx  <= LAST_IDX;
            found_any <= 1'b0;
            state     <= S_SCAN;
          end
        end
        S_SCAN: begin
          scan_idx <= scan_idx - IDX_W'(1);
          if (scan_idx == '0) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          state <= S_DECIDE;
        end
        S_DECIDE: begin
          if (rsp_load) begin
            active        <= active_next;
            stamp_counter <= stamp_counter_next;
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // The counter never lands on zero after a fill, wrap or not.
  `MSFS_ASSERT_NEXT(a_stamp_nonzero, rsp_load && miss, stamp_counter != '0,
                    "stamp counter zero after miss")
  // No read data may still be in flight while a new request can enter.
  `MSFS_ASSERT_NOW(a_idle_no_read, req_ready, !data_pend, "read pending while idle")
  // An ok activate always leaves the requested key active.
  `MSFS_ASSERT_NOW(a_active_ok,
                   rsp_load && !is_close && rsp_next.status == msfs_pkg::ST_OK,
                   rsp_next.active_key == req_q.map_key,
                   "ok activate left wrong active key")
  // An eviction always names a real key.
  `MSFS_ASSERT_NOW(a_evict_key, rsp_load && rsp_next.evicted_valid,
                   rsp_next.evicted_key != '0, "eviction with empty key")

endmodule
